>>> design/uart_baud_divisor_calc_macros.svh
// ----------------------------------------------------------------------------
// UART baud divisor calculator assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_CALC_MACROS_SVH
`define UART_BAUD_DIVISOR_CALC_MACROS_SVH

`ifndef SYNTHESIS

`define UBDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define UBDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UBDC_ASSERT_IMP(lbl, ante, cons, msg)

`define UBDC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> design/ubdc_pkg.sv
// ----------------------------------------------------------------------------
// ubdc_pkg
// Widths, constants and types shared by the baud divisor calculator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ubdc_pkg;

  localparam int CLK_W    = 27;
  localparam int BAUD_W   = 24;
  localparam int WORD_W   = 16;
  localparam int ST_W     = 2;

  // Dividend is 25 * clock_hz, divisor is 2 or 4 times the baud rate.
  localparam int NUM_W    = 32;
  localparam int REM_W    = 26;
  localparam logic [NUM_W-1:0] CLK_SCALE = 32'd25;

  // Post stages: scaled quotient below the limit fits in Q_W bits.
  localparam int Q_W      = 19;
  localparam logic [NUM_W-1:0] MANT_LIMIT = 32'd409600;
  localparam int MANT_W   = 12;
  localparam int FRAC_W   = 4;
  localparam int PROD_W   = 38;
  localparam int MANT_SHIFT = 25;
  // ceil(2^25 / 100); exact quotient for every value below the limit.
  localparam logic [Q_W-1:0] MANT_RECIP = 19'd335545;
  localparam logic [Q_W-1:0] CENT       = 19'd100;

  localparam int REMC_W   = 7;
  localparam logic [REMC_W-1:0] REMC_LIMIT = 7'd100;
  localparam int FX_W     = 11;
  localparam logic [FX_W-1:0] FRAC_ROUND = 11'd50;
  localparam int FY_W     = 22;
  localparam int FRAC_SHIFT = 17;
  // ceil(2^17 / 100); exact for rounded fraction sums up to 16 * 99 + 50.
  localparam logic [FX_W-1:0] FRAC_RECIP = 11'd1311;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAUD_ZERO = 2'd1,
    ST_MANT_BIG  = 2'd2
  } ubdc_status_t;

  // Word carried along the divider chain.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] den;
    logic             by8;
    logic             zero;
  } ubdc_div_t;

endpackage

`default_nettype wire

>>> design/uart_baud_divisor_calc.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_calc
// Fractional UART baud register calculator, pipelined one word per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Usage: present clock_hz, baud and over_sample_8 on the in_ channel with
// valid/ready; each accepted word yields exactly one out_ word holding the
// baud register value (mantissa in bits 15:4, fraction below) and a status:
// 0 ok, 1 zero baud rate, 2 mantissa above 4095. On an error the word is 0.
// The accepting edge loads the first of 32 divider cells, each resolving
// one quotient bit of 25*clock_hz / (k*baud), and three more stages follow
// for the mantissa multiply, the remainder modulo 100 and the rounded
// fraction with the output register, 35 registers in all. Throughput is
// one word per cycle while the receiver keeps taking results.
// Each stage moves forward whenever the stage after it is empty or moving,
// so bubbles close up and new words are taken while a finished result
// waits at the output. When the receiver stalls, the pipeline fills and
// in_ready drops only once every stage holds a word. Reset empties all
// stages; no request state survives it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uart_baud_divisor_calc
  import ubdc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CLK_W-1:0]  in_clock_hz,
  input  wire logic [BAUD_W-1:0] in_baud,
  input  wire logic              in_over_sample_8,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_divisor_word,
  output logic [ST_W-1:0]        out_status
);

  logic [NUM_W:0] chain_valid;
  logic [NUM_W:0] chain_ready;
  ubdc_div_t      chain_data [0:NUM_W];
  ubdc_div_t      init;

  always_comb begin
    init.rem  = '0;
    init.num  = NUM_W'(in_clock_hz) * CLK_SCALE;
    init.den  = in_over_sample_8 ? {1'b0, in_baud, 1'b0} : {in_baud, 2'b00};
    init.by8  = in_over_sample_8;
    init.zero = (in_baud == '0);
  end

  assign chain_valid[0] = in_valid;
  assign chain_data[0]  = init;
  assign in_ready       = chain_ready[0];

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    ubdc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  ubdc_post u_post (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (chain_valid[NUM_W]),
    .in_ready         (chain_ready[NUM_W]),
    .in_data          (chain_data[NUM_W]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_divisor_word (out_divisor_word),
    .out_status       (out_status)
  );

endmodule

`default_nettype wire

>>> design/ubdc_div_cell.sv
// ----------------------------------------------------------------------------
// ubdc_div_cell
// One restoring division step: produces one quotient bit and hands the
// partial remainder and shifted dividend on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ubdc_div_cell
  import ubdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      up_valid,
  output logic           up_ready,
  input  wire ubdc_div_t up_data,
  output logic           dn_valid,
  input  wire logic      dn_ready,
  output ubdc_div_t      dn_data
);

  logic      valid_r, valid_nxt;
  ubdc_div_t data_r, data_nxt;
  logic [REM_W:0] part;
  logic [REM_W:0] trial;

  assign up_ready = ~valid_r | dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    part     = {up_data.rem, up_data.num[NUM_W-1]};
    trial    = part - {1'b0, up_data.den};
    data_nxt = up_data;
    // The dividend shifts out at the top while quotient bits shift in below.
    if (!trial[REM_W]) begin
      data_nxt.rem = trial[REM_W-1:0];
      data_nxt.num = {up_data.num[NUM_W-2:0], 1'b1};
    end else begin
      data_nxt.rem = part[REM_W-1:0];
      data_nxt.num = {up_data.num[NUM_W-2:0], 1'b0};
    end
    valid_nxt = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/ubdc_post.sv
// ----------------------------------------------------------------------------
// ubdc_post
// Splits the scaled quotient into mantissa and rounded fraction, applies
// the error checks and holds the result word in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "uart_baud_divisor_calc_macros.svh"

module ubdc_post
  import ubdc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire ubdc_div_t    in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [WORD_W-1:0] out_divisor_word,
  output logic [ST_W-1:0]   out_status
);

  // Stage 1: range check and reciprocal multiply.
  logic              v1_r, v1_nxt, rdy1;
  logic [Q_W-1:0]    q1_r;
  logic [PROD_W-1:0] prod1_r, prod1_nxt;
  logic              by8_1_r;
  ubdc_status_t      st1_r, st1_nxt;

  // Stage 2: mantissa and remainder modulo 100.
  logic              v2_r, v2_nxt, rdy2;
  logic [MANT_W-1:0] mant2_r, mant2_nxt;
  logic [REMC_W-1:0] rem2_r, rem2_nxt;
  logic              by8_2_r;
  ubdc_status_t      st2_r;

  // Stage 3: rounded fraction and output register.
  logic              v3_r, v3_nxt, rdy3;
  logic [WORD_W-1:0] word3_r, word3_nxt;
  ubdc_status_t      st3_r;
  logic [FX_W-1:0]   fx;
  logic [FY_W-1:0]   fy;
  logic [FRAC_W-1:0] fq;
  logic [FRAC_W-1:0] frac;

  assign rdy3     = ~v3_r | out_ready;
  assign rdy2     = ~v2_r | rdy3;
  assign rdy1     = ~v1_r | rdy2;
  assign in_ready = rdy1;

  assign out_valid        = v3_r;
  assign out_divisor_word = word3_r;
  assign out_status       = st3_r;

  always_comb begin
    if (in_data.zero) begin
      st1_nxt = ST_BAUD_ZERO;
    end else if (in_data.num >= MANT_LIMIT) begin
      st1_nxt = ST_MANT_BIG;
    end else begin
      st1_nxt = ST_OK;
    end
    prod1_nxt = PROD_W'(in_data.num[Q_W-1:0]) * PROD_W'(MANT_RECIP);
    v1_nxt    = rdy1 ? in_valid : v1_r;
  end

  always_comb begin
    mant2_nxt = prod1_r[MANT_SHIFT +: MANT_W];
    rem2_nxt  = REMC_W'(q1_r - Q_W'(mant2_nxt) * CENT);
    v2_nxt    = rdy2 ? v1_r : v2_r;
  end

  always_comb begin
    if (by8_2_r) begin
      fx = {1'b0, rem2_r, 3'b000} + FRAC_ROUND;
    end else begin
      fx = {rem2_r, 4'b0000} + FRAC_ROUND;
    end
    fy = FY_W'(fx) * FY_W'(FRAC_RECIP);
    fq = fy[FRAC_SHIFT +: FRAC_W];
    // A rounding carry out of the fraction field is dropped by the mask.
    frac = by8_2_r ? {1'b0, fq[2:0]} : fq;
    if (st2_r == ST_OK) begin
      word3_nxt = {mant2_r, frac};
    end else begin
      word3_nxt = '0;
    end
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      q1_r    <= in_data.num[Q_W-1:0];
      prod1_r <= prod1_nxt;
      by8_1_r <= in_data.by8;
      st1_r   <= st1_nxt;
    end
    if (rdy2) begin
      mant2_r <= mant2_nxt;
      rem2_r  <= rem2_nxt;
      by8_2_r <= by8_1_r;
      st2_r   <= st1_r;
    end
    if (rdy3) begin
      word3_r <= word3_nxt;
      st3_r   <= st2_r;
    end
  end

  `UBDC_ASSERT_IMP(a_mant_range, v1_r && st1_r == ST_OK, prod1_r[PROD_W-1:MANT_SHIFT+MANT_W] == '0, "mantissa product out of range")
  `UBDC_ASSERT_IMP(a_rem_range, v2_r && st2_r == ST_OK, rem2_r < REMC_LIMIT, "remainder modulo 100 not below 100")
  `UBDC_ASSERT_IMP(a_err_zero, v3_r && st3_r != ST_OK, word3_r == '0, "error result with nonzero word")
  `UBDC_ASSERT_NXT(a_drain, v3_r && out_ready && !v2_r, !v3_r, "output word delivered twice")

endmodule

`default_nettype wire
